// ===== sv/odot_pkg.sv =====
// Package for the off-delay output timer.
// Holds the operation codes, the item and result structs and the field widths.
// No dependencies; every other file of the block uses it.
package odot_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DelayW  = 31;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 40;

  // Operation carried in tuser
  typedef enum logic [FuncW-1:0] {
    FUNC_SET_REQUEST = 3'd0,
    FUNC_SET_DELAY   = 3'd1,
    FUNC_CANCEL      = 3'd2,
    FUNC_TICK        = 3'd3,
    FUNC_FORCE_OFF   = 3'd4
  } func_e;

  // One input item, held in the input register
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic              request_on;
    logic [TimeW-1:0]  now_ms;
    logic [DelayW-1:0] delay_ms;
  } item_t;

  // One result item
  typedef struct packed {
    logic              active;
    logic              countdown;
    logic              changed;
    logic [DelayW-1:0] remaining_ms;
  } result_t;

endpackage

// ===== sv/odot_in_stage.sv =====
// Input register of the off-delay output timer.
// Captures one transaction from the slave stream; depends on odot_pkg.
module odot_in_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [odot_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic [odot_pkg::FuncW-1:0]          s_axis_tuser,
  input  logic                                advance_i,
  output logic                                valid_o,
  output odot_pkg::item_t                     item_o
);

  logic            valid_q, valid_d;
  odot_pkg::item_t item_q;
  logic            load;

  // Take a new transaction when empty or when the held one moves on
  assign s_axis_tready = !valid_q || advance_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unpack the payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.func       <= s_axis_tuser;
      item_q.request_on <= s_axis_tdata[0];
      item_q.now_ms     <= s_axis_tdata[32:1];
      item_q.delay_ms   <= s_axis_tdata[63:33];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/odot_core.sv =====
// Timer state and next-state logic of the off-delay output timer.
// Works out one result per item and updates the state when it moves on; uses odot_pkg.
module odot_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  odot_pkg::item_t   item_i,
  output odot_pkg::result_t result_o
);

  logic                          req_q, req_d;
  logic                          act_q, act_d;
  logic                          pend_q, pend_d;
  logic [odot_pkg::DelayW-1:0]   delay_q, delay_d;
  logic [odot_pkg::TimeW-1:0]    dl_q, dl_d;

  logic [odot_pkg::TimeW-1:0]    since_old;
  logic                          reached_old;
  logic [odot_pkg::TimeW-1:0]    arm_req;
  logic [odot_pkg::TimeW-1:0]    arm_new;
  logic [odot_pkg::TimeW-1:0]    since_new;
  logic [odot_pkg::TimeW-1:0]    left_new;
  logic [odot_pkg::DelayW-1:0]   remaining;

  // Wrap-safe test against the current deadline, and candidate deadlines
  assign since_old   = item_i.now_ms - dl_q;
  assign reached_old = !since_old[odot_pkg::TimeW-1];
  assign arm_req     = item_i.now_ms + {1'b0, delay_q};
  assign arm_new     = item_i.now_ms + {1'b0, item_i.delay_ms};

  // Next state for the operation
  always_comb begin
    req_d   = req_q;
    act_d   = act_q;
    pend_d  = pend_q;
    delay_d = delay_q;
    dl_d    = dl_q;
    unique case (item_i.func)
      odot_pkg::FUNC_SET_REQUEST: begin
        if (req_q == item_i.request_on) begin
          if (item_i.request_on) begin
            pend_d = 1'b0;
          end
        end else begin
          req_d = item_i.request_on;
          if (item_i.request_on) begin
            pend_d = 1'b0;
            act_d  = 1'b1;
          end else if (!act_q) begin
            pend_d = 1'b0;
          end else if (delay_q == '0) begin
            act_d  = 1'b0;
            pend_d = 1'b0;
          end else begin
            pend_d = 1'b1;
            dl_d   = arm_req;
          end
        end
      end
      odot_pkg::FUNC_SET_DELAY: begin
        delay_d = item_i.delay_ms;
        if (pend_q) begin
          if (item_i.delay_ms == '0) begin
            pend_d = 1'b0;
            act_d  = 1'b0;
          end else begin
            dl_d = arm_new;
          end
        end
      end
      odot_pkg::FUNC_CANCEL: begin
        pend_d = 1'b0;
      end
      odot_pkg::FUNC_TICK: begin
        if (pend_q && reached_old) begin
          pend_d = 1'b0;
          act_d  = 1'b0;
        end
      end
      odot_pkg::FUNC_FORCE_OFF: begin
        req_d  = 1'b0;
        pend_d = 1'b0;
        act_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Time left against the updated deadline, saturated to 31 bits
  assign since_new = item_i.now_ms - dl_d;
  assign left_new  = dl_d - item_i.now_ms;

  always_comb begin
    remaining = '0;
    if (pend_d && since_new[odot_pkg::TimeW-1]) begin
      if (left_new[odot_pkg::TimeW-1]) begin
        remaining = '1;
      end else begin
        remaining = left_new[odot_pkg::DelayW-1:0];
      end
    end
  end

  assign result_o.active       = act_d;
  assign result_o.countdown    = pend_d;
  assign result_o.changed      = act_d ^ act_q;
  assign result_o.remaining_ms = remaining;

  // Commit the state as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= 1'b0;
      act_q   <= 1'b0;
      pend_q  <= 1'b0;
      delay_q <= '0;
      dl_q    <= '0;
    end else if (advance_i) begin
      req_q   <= req_d;
      act_q   <= act_d;
      pend_q  <= pend_d;
      delay_q <= delay_d;
      dl_q    <= dl_d;
    end
  end

  // A countdown only runs while the output is on
  a_pend_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> act_q)
    else $error("countdown pending while output off");

  // State holds while no item moves on
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(act_q) && $stable(pend_q) && $stable(dl_q))
    else $error("timer state moved without an item");

endmodule

// ===== sv/odot_out_stage.sv =====
// Result register of the off-delay output timer.
// Holds one result transaction for the master stream; depends on odot_pkg.
module odot_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  odot_pkg::result_t               result_i,
  output logic                            busy_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [odot_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic              valid_q, valid_d;
  odot_pkg::result_t res_q;

  // Register is busy while a result waits and the sink stalls
  assign busy_o = valid_q && !m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  // Pack the result, zero padding up to whole bytes
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'd0, res_q.remaining_ms, res_q.changed,
                          res_q.countdown, res_q.active};

endmodule

// ===== sv/off_delay_output_timer.sv =====
// Off-delay output timer: one result transaction for every input transaction, in order.
// An item passes the input register, the timer logic and the result register, so a
// result is registered once its item moves on; one item per clock is sustained while the sink
// does not stall, as the timer state updates when each item moves between the two registers.
// Top level; depends on odot_pkg, odot_in_stage, odot_core and odot_out_stage.
module off_delay_output_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_on [0], now_ms [32:1], delay_ms [63:33]
  input  logic [63:0] s_axis_tdata,
  // func [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // active [0], countdown [1], changed [2], remaining_ms [33:3], zero [39:34]
  output logic [39:0] m_axis_tdata
);

  logic              in_valid;
  odot_pkg::item_t   item;
  odot_pkg::result_t result;
  logic              out_busy;
  logic              advance;

  // Move an item on whenever the result register can take it
  assign advance = in_valid && !out_busy;

  odot_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  odot_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  odot_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .result_i      (result),
    .busy_o        (out_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // An item that moves on always produces a result next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("item advanced without a result");

  // Time left is only reported during a countdown
  a_rem_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:3] != 31'd0) |-> m_axis_tdata[1])
    else $error("remaining time without countdown");

  // A countdown is only reported while the output is on
  a_cool_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("countdown reported with output off");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the off-delay output timer.
// Drives timer events over the input stream, predicts each status result and compares it.
// Depends on odot_pkg and the off_delay_output_timer top level.
module tb;

  // Codes that the block does not decode
  localparam logic [odot_pkg::FuncW-1:0] FuncUnusedFirst = 3'd5;
  localparam logic [odot_pkg::FuncW-1:0] FuncUnusedMid   = 3'd6;
  localparam logic [odot_pkg::FuncW-1:0] FuncUnusedLast  = 3'd7;
  localparam int unsigned                StallLimit      = 4000;
  localparam logic [31:0]                RemainMax       = 32'h7FFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // request_on [0], now_ms [32:1], delay_ms [63:33]
  logic [63:0] s_axis_tdata;
  // func [2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // active [0], countdown [1], changed [2], remaining_ms [33:3], zero [39:34]
  logic [39:0] m_axis_tdata;

  // Predicted timer state
  logic                        tmr_request  = 1'b0;
  logic                        tmr_active   = 1'b0;
  logic                        tmr_cooling  = 1'b0;
  logic [odot_pkg::DelayW-1:0] tmr_delay    = '0;
  logic [odot_pkg::TimeW-1:0]  tmr_deadline = '0;

  odot_pkg::result_t          status_due[$];
  int                         mismatches   = 0;
  int                         results_seen = 0;
  bit                         no_idle      = 1'b0;
  logic [odot_pkg::TimeW-1:0] sim_ms       = '0;

  off_delay_output_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Wrap-safe test: now at or past the deadline
  function automatic logic deadline_passed(input logic [odot_pkg::TimeW-1:0] now);
    logic [odot_pkg::TimeW-1:0] diff;
    diff = now - tmr_deadline;
    return !diff[odot_pkg::TimeW-1];
  endfunction

  // Apply one event to the predicted state and queue the status it yields
  task automatic advance_timer(input logic [odot_pkg::FuncW-1:0] func, input logic req,
                               input logic [odot_pkg::TimeW-1:0] now,
                               input logic [odot_pkg::DelayW-1:0] delay);
    odot_pkg::result_t          st;
    logic                       was_active;
    logic [odot_pkg::TimeW-1:0] left;
    was_active = tmr_active;
    left = '0;
    case (func)
      odot_pkg::FUNC_SET_REQUEST: begin
        if (tmr_request == req) begin
          if (req) tmr_cooling = 1'b0;
        end else begin
          tmr_request = req;
          if (req) begin
            tmr_cooling = 1'b0;
            tmr_active  = 1'b1;
          end else if (!tmr_active) begin
            tmr_cooling = 1'b0;
          end else if (tmr_delay == '0) begin
            tmr_active  = 1'b0;
            tmr_cooling = 1'b0;
          end else begin
            tmr_cooling  = 1'b1;
            tmr_deadline = now + {1'b0, tmr_delay};
          end
        end
      end
      odot_pkg::FUNC_SET_DELAY: begin
        tmr_delay = delay;
        if (tmr_cooling) begin
          if (delay == '0) begin
            tmr_cooling = 1'b0;
            tmr_active  = 1'b0;
          end else begin
            tmr_deadline = now + {1'b0, delay};
          end
        end
      end
      odot_pkg::FUNC_CANCEL: tmr_cooling = 1'b0;
      odot_pkg::FUNC_TICK: begin
        if (tmr_cooling && deadline_passed(now)) begin
          tmr_cooling = 1'b0;
          tmr_active  = 1'b0;
        end
      end
      odot_pkg::FUNC_FORCE_OFF: begin
        tmr_request = 1'b0;
        tmr_cooling = 1'b0;
        tmr_active  = 1'b0;
      end
      default: ;
    endcase
    // Time left saturates when a timestamp has gone backwards
    if (tmr_cooling && !deadline_passed(now)) begin
      left = tmr_deadline - now;
      if (left > RemainMax) left = RemainMax;
    end
    st.active       = tmr_active;
    st.countdown    = tmr_cooling;
    st.changed      = (was_active != tmr_active);
    st.remaining_ms = left[odot_pkg::DelayW-1:0];
    status_due.push_back(st);
  endtask

  // Offer one event; hold it until the transaction completes, then predict
  task automatic send_item(input logic [odot_pkg::FuncW-1:0] func, input logic req,
                           input logic [odot_pkg::TimeW-1:0] now,
                           input logic [odot_pkg::DelayW-1:0] delay);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {delay, now, req};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_timer(func, req, now, delay);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s on result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    odot_pkg::result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with nothing predicted", m_axis_tdata[31:0], '0);
      end else begin
        want = status_due.pop_front();
        if (m_axis_tdata[0] !== want.active)
          report_mismatch("active", 32'(m_axis_tdata[0]), 32'(want.active));
        if (m_axis_tdata[1] !== want.countdown)
          report_mismatch("countdown", 32'(m_axis_tdata[1]), 32'(want.countdown));
        if (m_axis_tdata[2] !== want.changed)
          report_mismatch("changed", 32'(m_axis_tdata[2]), 32'(want.changed));
        if (m_axis_tdata[33:3] !== want.remaining_ms)
          report_mismatch("remaining_ms", 32'(m_axis_tdata[33:3]),
                          32'(want.remaining_ms));
      end
      results_seen++;
    end
  end

  // Receiver: ready for random stretches, stalled for random gaps
  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (no_idle) begin
        m_axis_tready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        hold = pick_gap();
      end else begin
        m_axis_tready <= 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Edges of the fields and each corner of the request handling
  task automatic test_directed_cases();
    send_item(odot_pkg::FUNC_TICK, 1'b0, 32'h0, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'h0, 31'h7FFF_FFFF);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'h1, 31'h0);
    // zero delay: off at once
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'h5, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'h6, 31'h0);
    send_item(odot_pkg::FUNC_SET_DELAY, 1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'hFFFF_FFFF, 31'h0);
    // deadline at half the range; stepping back saturates the time left
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'h1, 31'h0);
    send_item(odot_pkg::FUNC_TICK, 1'b1, 32'h0, 31'h7FFF_FFFF);
    send_item(odot_pkg::FUNC_TICK, 1'b0, 32'h7FFF_FFFF, 31'h0);
    send_item(odot_pkg::FUNC_TICK, 1'b0, 32'h8000_0000, 31'h0);
    send_item(odot_pkg::FUNC_SET_DELAY, 1'b0, 32'd100, 31'd10);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'd100, 31'h0);
    // countdown across the wrap of the timestamp
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'hFFFF_FFFA, 31'h0);
    send_item(odot_pkg::FUNC_TICK, 1'b0, 32'hFFFF_FFFF, 31'h0);
    // on again while cooling down: countdown dropped, no pulse
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'h0, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'd10, 31'h0);
    // new delay re-arms from now
    send_item(odot_pkg::FUNC_SET_DELAY, 1'b0, 32'd15, 31'd50);
    send_item(odot_pkg::FUNC_TICK, 1'b0, 32'd64, 31'h0);
    send_item(odot_pkg::FUNC_SET_DELAY, 1'b0, 32'd64, 31'h7FFF_FFFF);
    send_item(odot_pkg::FUNC_CANCEL, 1'b1, 32'd64, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'd70, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'd70, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b0, 32'd80, 31'h0);
    // zero delay during a countdown ends it
    send_item(odot_pkg::FUNC_SET_DELAY, 1'b0, 32'd90, 31'h0);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'd95, 31'h0);
    send_item(odot_pkg::FUNC_FORCE_OFF, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(odot_pkg::FUNC_SET_REQUEST, 1'b1, 32'd99, 31'h0);
    send_item(FuncUnusedFirst, 1'b1, 32'd100, 31'h7FFF_FFFF);
    send_item(FuncUnusedMid, 1'b0, 32'd100, 31'h0);
    send_item(FuncUnusedLast, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  // One event on a mostly advancing clock, with short delays so deadlines expire
  task automatic send_timed_item();
    int                          pick;
    int                          jump;
    logic [odot_pkg::FuncW-1:0]  func;
    logic                        req;
    logic [odot_pkg::DelayW-1:0] delay;
    pick = $urandom_range(0, 99);
    jump = $urandom_range(0, 99);
    req  = 1'($urandom_range(0, 1));
    delay = 31'($urandom());
    if (jump < 2) sim_ms = $urandom();
    else if (jump < 4) sim_ms = sim_ms - $urandom_range(1, 200);
    else sim_ms = sim_ms + $urandom_range(0, 15);
    if (pick < 35) begin
      func = odot_pkg::FUNC_SET_REQUEST;
    end else if (pick < 45) begin
      func = odot_pkg::FUNC_SET_DELAY;
      jump = $urandom_range(0, 99);
      if (jump < 15) delay = '0;
      else if (jump < 85) delay = 31'($urandom_range(1, 40));
    end else if (pick < 50) begin
      func = odot_pkg::FUNC_CANCEL;
    end else if (pick < 90) begin
      func = odot_pkg::FUNC_TICK;
    end else if (pick < 95) begin
      func = odot_pkg::FUNC_FORCE_OFF;
    end else begin
      func = 3'($urandom_range(FuncUnusedFirst, FuncUnusedLast));
    end
    send_item(func, req, sim_ms, delay);
  endtask

  task automatic test_timed_sequences();
    for (int i = 0; i < 1100; i++) begin
      if (i % 150 == 0) sim_ms = $urandom();
      send_timed_item();
    end
  endtask

  // Every field fully random, unused codes included
  task automatic test_random_noise();
    for (int i = 0; i < 250; i++)
      send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom(),
                31'($urandom()));
  endtask

  // Same traffic with no idling on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 170; i++) send_timed_item();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_timed_sequences();
    test_random_noise();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    // Drain the outstanding results, then allow for the pipeline
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
